/* hw/rtl/flow_field_modifier_ipv4_csum_defines.svh */
// assertion macros shared by the checker of the flow field modifier
`ifndef FLOW_FIELD_MODIFIER_IPV4_CSUM_DEFINES_SVH
`define FLOW_FIELD_MODIFIER_IPV4_CSUM_DEFINES_SVH

// property checked outside reset
`define FFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also holds across reset
`define FFM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ffm_pkg.sv */
// types, register indexes and header helpers of the flow field modifier
`default_nettype none
package ffm_pkg;

  localparam logic [2:0] REG_BASE_SRC    = 3'd0;
  localparam logic [2:0] REG_BASE_DST    = 3'd1;
  localparam logic [2:0] REG_BASE_PORTS  = 3'd2;
  localparam logic [2:0] REG_SRC_COUNT   = 3'd3;
  localparam logic [2:0] REG_DST_COUNT   = 3'd4;
  localparam logic [2:0] REG_PORT_COUNTS = 3'd5;
  localparam logic [2:0] REG_TOTAL_LEN   = 3'd6;
  localparam logic [2:0] REG_OFFLOAD     = 3'd7;

  localparam logic [15:0] TOTAL_LEN_RESET = 16'd46;

  // template header words: version/ihl/tos and ttl/protocol
  localparam logic [7:0]  VER_IHL     = 8'(4 << 4) | 8'd5;
  localparam logic [7:0]  TTL         = 8'd64;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] WORD_VER    = {VER_IHL, 8'd0};
  localparam logic [15:0] WORD_TTL    = {TTL, PROTO_UDP};

  typedef struct packed {
    logic [31:0] base_src;
    logic [31:0] base_dst;
    logic [31:0] base_ports;
    logic [31:0] src_count;
    logic [31:0] dst_count;
    logic [31:0] port_counts;
    logic [15:0] ip_len;
    logic        offload;
  } cfg_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [63:0] index;
  } flow_word_t;

  // wrapping step counter update; count 0 or 1 holds it at zero
  function automatic logic [31:0] next_step(input logic [31:0] step,
                                            input logic [31:0] count);
    logic [32:0] inc;
    begin
      inc = {1'b0, step} + 33'd1;
      if (count[31:1] == 31'd0 || inc >= {1'b0, count}) begin
        next_step = 32'd0;
      end else begin
        next_step = inc[31:0];
      end
    end
  endfunction

  function automatic logic [15:0] header_checksum(input logic [15:0] len,
                                                  input logic [31:0] src,
                                                  input logic [31:0] dst);
    logic [18:0] sum;
    logic [16:0] fold1;
    logic [16:0] fold2;
    begin
      sum = 19'(WORD_VER) + 19'(len) + 19'(WORD_TTL)
          + 19'(src[31:16]) + 19'(src[15:0]) + 19'(dst[31:16]) + 19'(dst[15:0]);
      fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
      fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
      header_checksum = ~fold2[15:0];
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ffm_flow_step.sv */
// sequence and step counters, rewritten flow fields into the stage register
`default_nettype none
module ffm_flow_step (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ffm_pkg::cfg_t         cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  restart,
  output logic                       word_valid,
  output ffm_pkg::flow_word_t        word,
  input  wire logic                  word_ready
);

  logic [63:0] seq;
  logic [31:0] src_step;
  logic [31:0] dst_step;
  logic [15:0] sport_step;
  logic [15:0] dport_step;

  logic        take;
  logic [63:0] seq_use;
  logic [31:0] src_use;
  logic [31:0] dst_use;
  logic [15:0] sport_use;
  logic [15:0] dport_use;
  logic [15:0] sp_count;
  logic [15:0] dp_count;
  ffm_pkg::flow_word_t word_next;

  assign in_ready = !word_valid || word_ready;
  assign take     = in_valid && in_ready;
  assign sp_count = cfg.port_counts[31:16];
  assign dp_count = cfg.port_counts[15:0];

  // restart zeroes the counters before this word is built
  always_comb begin
    seq_use   = restart ? 64'd0 : seq;
    src_use   = restart ? 32'd0 : src_step;
    dst_use   = restart ? 32'd0 : dst_step;
    sport_use = restart ? 16'd0 : sport_step;
    dport_use = restart ? 16'd0 : dport_step;

    word_next.src   = cfg.base_src;
    word_next.dst   = cfg.base_dst;
    word_next.sport = cfg.base_ports[31:16];
    word_next.dport = cfg.base_ports[15:0];
    word_next.index = seq_use;
    if (cfg.src_count[31:1] != 31'd0) begin
      word_next.src = cfg.base_src + src_use;
    end
    if (cfg.dst_count[31:1] != 31'd0) begin
      word_next.dst = cfg.base_dst + dst_use;
    end
    if (sp_count[15:1] != 15'd0) begin
      word_next.sport = cfg.base_ports[31:16] + sport_use;
    end
    if (dp_count[15:1] != 15'd0) begin
      word_next.dport = cfg.base_ports[15:0] + dport_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= 64'd0;
      src_step   <= 32'd0;
      dst_step   <= 32'd0;
      sport_step <= 16'd0;
      dport_step <= 16'd0;
      word_valid <= 1'b0;
    end else begin
      if (take) begin
        seq        <= seq_use + 64'd1;
        src_step   <= ffm_pkg::next_step(src_use, cfg.src_count);
        dst_step   <= ffm_pkg::next_step(dst_use, cfg.dst_count);
        sport_step <= 16'(ffm_pkg::next_step({16'd0, sport_use}, {16'd0, sp_count}));
        dport_step <= 16'(ffm_pkg::next_step({16'd0, dport_use}, {16'd0, dp_count}));
      end
      if (in_ready) begin
        word_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word <= word_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ffm_csum.sv */
// header checksum and result register
`default_nettype none
module ffm_csum (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ffm_pkg::cfg_t         cfg,
  input  wire logic                  word_valid,
  input  wire ffm_pkg::flow_word_t   word,
  output logic                       word_ready,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [31:0]                source_address,
  output logic [31:0]                destination_address,
  output logic [15:0]                source_port,
  output logic [15:0]                destination_port,
  output logic [15:0]                header_checksum,
  output logic [63:0]                packet_index
);

  logic [15:0] csum_next;

  assign word_ready = !result_valid || !result_stall;

  always_comb begin
    if (cfg.offload) begin
      csum_next = 16'd0;
    end else begin
      csum_next = ffm_pkg::header_checksum(cfg.ip_len, word.src, word.dst);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (word_ready) begin
      result_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_ready && word_valid) begin
      source_address      <= word.src;
      destination_address <= word.dst;
      source_port         <= word.sport;
      destination_port    <= word.dport;
      header_checksum     <= csum_next;
      packet_index        <= word.index;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/flow_field_modifier_ipv4_csum.sv */
// top level of the flow field modifier with ipv4 header checksum
//
//   channel   direction  handshake                     payload
//   request   in         request_valid / request_stall restart_sequence
//   result    out        result_valid / result_stall   addresses, ports, checksum, index
//   config    in         cfg_write                     cfg_index, cfg_data
//
// one word per cycle sustained while result_stall is low; two register stages: the word register
// (counters and field adds) loads at acceptance, the result register
// (checksum adder) loads from the word register when it is not stalled.
// synchronous reset clears counters, valid flags and config registers to defaults.
// a stalled result holds while the counter stage still takes one more word.
`default_nettype none
module flow_field_modifier_ipv4_csum (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        request_valid,
  output logic             request_stall,
  input  wire logic        restart_sequence,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      source_address,
  output logic [31:0]      destination_address,
  output logic [15:0]      source_port,
  output logic [15:0]      destination_port,
  output logic [15:0]      header_checksum,
  output logic [63:0]      packet_index
);

  ffm_pkg::cfg_t       cfg;
  ffm_pkg::flow_word_t word;
  logic                word_valid;
  logic                word_ready;
  logic                req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_src     <= 32'd0;
      cfg.base_dst     <= 32'd0;
      cfg.base_ports   <= 32'd0;
      cfg.src_count    <= 32'd0;
      cfg.dst_count    <= 32'd0;
      cfg.port_counts  <= 32'd0;
      cfg.ip_len       <= ffm_pkg::TOTAL_LEN_RESET;
      cfg.offload      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        ffm_pkg::REG_BASE_SRC:    cfg.base_src     <= cfg_data;
        ffm_pkg::REG_BASE_DST:    cfg.base_dst     <= cfg_data;
        ffm_pkg::REG_BASE_PORTS:  cfg.base_ports   <= cfg_data;
        ffm_pkg::REG_SRC_COUNT:   cfg.src_count    <= cfg_data;
        ffm_pkg::REG_DST_COUNT:   cfg.dst_count    <= cfg_data;
        ffm_pkg::REG_PORT_COUNTS: cfg.port_counts  <= cfg_data;
        ffm_pkg::REG_TOTAL_LEN:   cfg.ip_len       <= cfg_data[15:0];
        ffm_pkg::REG_OFFLOAD:     cfg.offload      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign request_stall = !req_ready;

  ffm_flow_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (request_valid),
    .in_ready   (req_ready),
    .restart    (restart_sequence),
    .word_valid (word_valid),
    .word       (word),
    .word_ready (word_ready)
  );

  ffm_csum u_csum (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .word_valid          (word_valid),
    .word                (word),
    .word_ready          (word_ready),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .source_address      (source_address),
    .destination_address (destination_address),
    .source_port         (source_port),
    .destination_port    (destination_port),
    .header_checksum     (header_checksum),
    .packet_index        (packet_index)
  );

endmodule
`default_nettype wire

/* hw/rtl/ffm_checker.sv */
// port-level checks of the flow field modifier and their bind
`default_nettype none
`include "flow_field_modifier_ipv4_csum_defines.svh"
module ffm_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        request_stall,
  input  wire logic        result_valid,
  input  wire logic        result_stall,
  input  wire logic [15:0] header_checksum,
  input  wire logic [63:0] packet_index
);

  logic        seen;
  logic [63:0] last_index;
  logic        out_take;

  assign out_take   = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_take) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      last_index <= packet_index;
    end
  end

  // each word continues the sequence unless a restart brought it back to zero
  `FFM_ASSERT(a_index_seq, out_take && seen |-> packet_index == last_index + 64'd1 || packet_index == 64'd0, "packet index skipped")
  // an empty result register leaves the request side free
  `FFM_ASSERT(a_no_stall_empty, !result_valid |-> !request_stall, "request stalled with empty pipeline")
  // the folded header sum is never zero, so the checksum never reads all ones
  `FFM_ASSERT(a_csum_range, result_valid |-> header_checksum != 16'hFFFF, "impossible header checksum")
  `FFM_ASSERT(a_hold, result_valid && result_stall |=> result_valid && $stable(packet_index), "stalled result changed")
  `FFM_ASSERT_RST(a_reset_empty, rst |=> !result_valid, "result valid after reset")

endmodule

bind flow_field_modifier_ipv4_csum ffm_checker u_ffm_checker (.*);
`default_nettype wire

/* verif/tb_flow_field_modifier_ipv4_csum.sv */
// testbench of the flow field modifier: predicted rewritten flow words checked against the block
module tb_flow_field_modifier_ipv4_csum;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] HDR_VER_WORD  = 16'h4500;
  localparam logic [15:0] HDR_TTL_WORD  = {8'd64, 8'd17};
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_WORDS   = 125;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 5000;
  localparam logic [7:0] ALL_REGS = 8'hFF;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] csum;
    logic [63:0] index;
  } flow_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = ffm_pkg::REG_BASE_SRC;
  logic [31:0] cfg_data = 32'd0;
  logic        request_valid = 1'b0;
  logic        request_stall;
  logic        restart_sequence = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [15:0] header_checksum;
  logic [63:0] packet_index;

  flow_field_modifier_ipv4_csum DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .request_valid, .request_stall, .restart_sequence,
    .result_valid, .result_stall,
    .source_address, .destination_address, .source_port, .destination_port,
    .header_checksum, .packet_index
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // register copies as the block holds them, and the values to program next
  logic [31:0] reg_shadow [8];
  logic [31:0] reg_next [8];

  // predicted flow state
  logic [63:0] seq_num = 64'd0;
  logic [31:0] src_step = 32'd0;
  logic [31:0] dst_step = 32'd0;
  logic [15:0] sport_step = 16'd0;
  logic [15:0] dport_step = 16'd0;

  bit           pending_requests [$];
  flow_result_t expected_flows [$];

  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;
  int send_gap = 0;
  int recv_wait = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int fault_count = 0;
  int quiet_cycles = 0;

  function automatic logic [31:0] advance_step(input logic [31:0] step,
                                               input logic [31:0] count);
    if (count <= 32'd1) return 32'd0;
    if ({1'b0, step} + 33'd1 >= {1'b0, count}) return 32'd0;
    return step + 32'd1;
  endfunction

  function automatic flow_result_t next_flow(input logic restart);
    flow_result_t r;
    logic [15:0] sp_count;
    logic [15:0] dp_count;
    logic [31:0] sum;
    sp_count = reg_shadow[ffm_pkg::REG_PORT_COUNTS][31:16];
    dp_count = reg_shadow[ffm_pkg::REG_PORT_COUNTS][15:0];
    if (restart) begin
      seq_num = 64'd0;
      src_step = 32'd0;
      dst_step = 32'd0;
      sport_step = 16'd0;
      dport_step = 16'd0;
    end
    r.src = reg_shadow[ffm_pkg::REG_BASE_SRC];
    if (reg_shadow[ffm_pkg::REG_SRC_COUNT] > 32'd1) r.src = r.src + src_step;
    r.dst = reg_shadow[ffm_pkg::REG_BASE_DST];
    if (reg_shadow[ffm_pkg::REG_DST_COUNT] > 32'd1) r.dst = r.dst + dst_step;
    r.sport = reg_shadow[ffm_pkg::REG_BASE_PORTS][31:16];
    if (sp_count > 16'd1) r.sport = r.sport + sport_step;
    r.dport = reg_shadow[ffm_pkg::REG_BASE_PORTS][15:0];
    if (dp_count > 16'd1) r.dport = r.dport + dport_step;
    sum = 32'(HDR_VER_WORD) + 32'(reg_shadow[ffm_pkg::REG_TOTAL_LEN][15:0])
        + 32'(HDR_TTL_WORD)
        + 32'(r.src[31:16]) + 32'(r.src[15:0]) + 32'(r.dst[31:16]) + 32'(r.dst[15:0]);
    sum = {16'd0, sum[15:0]} + (sum >> 16);
    sum = {16'd0, sum[15:0]} + (sum >> 16);
    r.csum = reg_shadow[ffm_pkg::REG_OFFLOAD][0] ? 16'd0 : ~sum[15:0];
    r.index = seq_num;
    seq_num = seq_num + 64'd1;
    src_step = advance_step(src_step, reg_shadow[ffm_pkg::REG_SRC_COUNT]);
    dst_step = advance_step(dst_step, reg_shadow[ffm_pkg::REG_DST_COUNT]);
    sport_step = 16'(advance_step({16'd0, sport_step}, {16'd0, sp_count}));
    dport_step = 16'(advance_step({16'd0, dport_step}, {16'd0, dp_count}));
    return r;
  endfunction

  task automatic note_fault(input string msg);
    if (fault_count < 10) $display("mismatch: %s", msg);
    fault_count++;
  endtask

  // driver: one request word per pop, random gap before the next unless the sender is steady
  always @(posedge clk) begin
    if (rst) begin
      request_valid <= 1'b0;
    end else begin
      if (request_valid && !request_stall) begin
        expected_flows.push_back(next_flow(restart_sequence));
      end
      if (!request_valid || !request_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          request_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          restart_sequence <= pending_requests.pop_front();
          request_valid <= 1'b1;
          send_gap = sender_steady ? 0 : $urandom_range(0, 6);
        end else begin
          request_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word and draws the receiver stall
  always @(posedge clk) begin : monitor
    flow_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_flows.size() == 0) begin
          note_fault($sformatf("result word with none expected, index %0d", packet_index));
        end else begin
          want = expected_flows.pop_front();
          if (source_address !== want.src)
            note_fault($sformatf("source_address expected %h got %h",
                                 want.src, source_address));
          if (destination_address !== want.dst)
            note_fault($sformatf("destination_address expected %h got %h",
                                 want.dst, destination_address));
          if (source_port !== want.sport)
            note_fault($sformatf("source_port expected %h got %h", want.sport, source_port));
          if (destination_port !== want.dport)
            note_fault($sformatf("destination_port expected %h got %h",
                                 want.dport, destination_port));
          if (header_checksum !== want.csum)
            note_fault($sformatf("header_checksum expected %h got %h",
                                 want.csum, header_checksum));
          if (packet_index !== want.index)
            note_fault($sformatf("packet_index expected %h got %h", want.index, packet_index));
        end
        recv_wait = receiver_steady ? 0 : $urandom_range(0, 6);
      end
      if (hold_asked != hold_taken) begin
        hold_taken = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (request_valid && !request_stall) || (result_valid && !result_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || request_valid || expected_flows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] mask);
    for (int i = 0; i < 8; i++) begin
      if (mask[i]) begin
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= 3'(i);
        cfg_data <= reg_next[i];
        reg_shadow[i] = reg_next[i];
      end
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // mix of fixed, small wrapping, mid-size and full-range counts
  function automatic logic [31:0] random_count();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1);
      1: return $urandom_range(2, 16);
      2: return $urandom;
      default: return $urandom_range(2, 300);
    endcase
  endfunction

  function automatic logic [31:0] random_base();
    if ($urandom_range(0, 3) == 0) return 32'hFFFF_FFFF - $urandom_range(0, 8);
    return $urandom;
  endfunction

  initial begin : stimulus
    int p;
    int i;
    bit restart_first;
    for (i = 0; i < 8; i++) begin
      reg_shadow[i] = 32'd0;
      reg_next[i] = 32'd0;
    end
    reg_shadow[ffm_pkg::REG_TOTAL_LEN] = 32'(ffm_pkg::TOTAL_LEN_RESET);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: every field fixed at zero base
    pending_requests.push_back(1'b0);
    pending_requests.push_back(1'b1);
    pending_requests.push_back(1'b0);
    pending_requests.push_back(1'b0);
    wait_idle();

    // bases at the top so addresses and ports wrap, fixed destination, max length
    reg_next[ffm_pkg::REG_BASE_SRC]    = 32'hFFFF_FFFE;
    reg_next[ffm_pkg::REG_BASE_DST]    = 32'hFFFF_FFFF;
    reg_next[ffm_pkg::REG_BASE_PORTS]  = 32'hFFFF_FFFE;
    reg_next[ffm_pkg::REG_SRC_COUNT]   = 32'd5;
    reg_next[ffm_pkg::REG_DST_COUNT]   = 32'd1;
    reg_next[ffm_pkg::REG_PORT_COUNTS] = 32'h0004_0003;
    reg_next[ffm_pkg::REG_TOTAL_LEN]   = 32'h0000_FFFF;
    reg_next[ffm_pkg::REG_OFFLOAD]     = 32'd0;
    program_regs(ALL_REGS);
    pending_requests.push_back(1'b1);
    repeat (7) pending_requests.push_back(1'b0);
    wait_idle();

    // largest destination and source port counts, zero length, offload on
    reg_next[ffm_pkg::REG_SRC_COUNT]   = 32'd10;
    reg_next[ffm_pkg::REG_DST_COUNT]   = 32'hFFFF_FFFF;
    reg_next[ffm_pkg::REG_PORT_COUNTS] = 32'hFFFF_0000;
    reg_next[ffm_pkg::REG_TOTAL_LEN]   = 32'd0;
    reg_next[ffm_pkg::REG_OFFLOAD]     = 32'd1;
    program_regs(ALL_REGS);
    pending_requests.push_back(1'b1);
    repeat (6) pending_requests.push_back(1'b0);
    wait_idle();

    // source count shrinks below the current step, length just under minimum
    reg_next[ffm_pkg::REG_SRC_COUNT] = 32'd3;
    reg_next[ffm_pkg::REG_TOTAL_LEN] = 32'd27;
    reg_next[ffm_pkg::REG_OFFLOAD]   = 32'd0;
    program_regs((8'd1 << ffm_pkg::REG_SRC_COUNT) | (8'd1 << ffm_pkg::REG_TOTAL_LEN)
                 | (8'd1 << ffm_pkg::REG_OFFLOAD));
    repeat (4) pending_requests.push_back(1'b0);

    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      reg_next[ffm_pkg::REG_BASE_SRC]    = random_base();
      reg_next[ffm_pkg::REG_BASE_DST]    = random_base();
      reg_next[ffm_pkg::REG_BASE_PORTS]  = random_base();
      reg_next[ffm_pkg::REG_SRC_COUNT]   = random_count();
      reg_next[ffm_pkg::REG_DST_COUNT]   = random_count();
      reg_next[ffm_pkg::REG_PORT_COUNTS] = {16'(random_count()), 16'(random_count())};
      case ($urandom_range(0, 3))
        0: reg_next[ffm_pkg::REG_TOTAL_LEN] = $urandom_range(0, 27);
        1: reg_next[ffm_pkg::REG_TOTAL_LEN] = 32'h0000_FFFF;
        2: reg_next[ffm_pkg::REG_TOTAL_LEN] = $urandom;
        default: reg_next[ffm_pkg::REG_TOTAL_LEN] = $urandom_range(28, 1500);
      endcase
      reg_next[ffm_pkg::REG_OFFLOAD] = ($urandom_range(0, 2) == 0) ? $urandom
                                     : {$urandom} & 32'hFFFF_FFFE;
      program_regs(p == 0 || $urandom_range(0, 2) == 0 ? ALL_REGS : 8'($urandom_range(1, 255)));
      sender_steady = (p == 2) || ($urandom_range(0, 3) == 0);
      receiver_steady = (p != 2) && ($urandom_range(0, 3) == 0);
      // long receiver hold while the sender keeps offering, so the block backs up
      if (p == 2 || $urandom_range(0, 7) == 0) hold_asked++;
      restart_first = $urandom_range(0, 1);
      for (i = 0; i < PHASE_WORDS; i++) begin
        // sender waits for the block to drain halfway through one phase
        if (p == 5 && i == PHASE_WORDS / 2) wait_idle();
        pending_requests.push_back((i == 0 && restart_first) || ($urandom_range(0, 29) == 0));
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fault_count == 0 && expected_flows.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
